### design/cpfm_pkg.sv
// Shared constants and types of the capture pair frequency meter.
// No dependencies; used by capture_pair_frequency_meter_core.
package cpfm_pkg;

   localparam int unsigned TIMER_WIDTH_DEFAULT = 16;
   localparam int unsigned CAPTURE_W           = 16;
   localparam int unsigned PERIOD_W            = 16;
   localparam int unsigned TICK_RATE_W         = 27;
   localparam int unsigned CSR_DATA_W          = 32;
   localparam int unsigned CSR_ADDR_W          = 3;

   localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 27'd2000000;

   localparam logic CSR_IDX_TICK_RATE = 1'b0;

   localparam int unsigned DIV_STEPS = TICK_RATE_W;
   localparam int unsigned COUNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

### design/capture_pair_frequency_meter_core.sv
// Capture pair frequency meter: period and reciprocal frequency from timestamp pairs.
// Depends on cpfm_pkg.
//
// Timestamps arrive in disjoint pairs; the first of a pair is stored and gives no
// result, the second gives the period (modulo the timer width) and tick_rate_hz /
// period as a truncated integer. The quotient comes from a restoring divider that
// retires one quotient bit per cycle, so a second capture occupies the block through
// the load, a divide step for each of the 27 quotient bits and ST_FINISH, which posts
// the result once the output register can take it; when the period is zero no division
// runs. The result sits in an output register, so the next first capture is taken while
// it waits. req_stall is high whenever a pair is being worked on.
module capture_pair_frequency_meter_core #(
   parameter int unsigned TIMER_WIDTH = cpfm_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cpfm_pkg::CAPTURE_W-1:0]       req_capture_time,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cpfm_pkg::PERIOD_W-1:0]        rsp_period_count,
   output logic [cpfm_pkg::TICK_RATE_W-1:0]     rsp_frequency_hz,
   output logic                                 rsp_zero_period,

   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cpfm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cpfm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cpfm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int unsigned TW  = TIMER_WIDTH;
   localparam int unsigned QW  = cpfm_pkg::TICK_RATE_W;
   localparam int unsigned CW  = cpfm_pkg::COUNT_W;

   cpfm_pkg::state_type state_ff, state_in;

   logic [QW-1:0]  tick_rate_ff, tick_rate_in;
   logic           pending_ff, pending_in;
   logic [TW-1:0]  first_ff, first_in;
   logic [TW-1:0]  divisor_ff, divisor_in;
   logic [TW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           zero_ff, zero_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cpfm_pkg::PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic [QW-1:0]                 rsp_freq_ff, rsp_freq_in;
   logic                          rsp_zero_ff, rsp_zero_in;

   logic           req_take;
   logic           csr_write;
   logic [TW-1:0]  stamp;
   logic [TW-1:0]  period;
   logic [TW:0]    rem_shift;
   logic [TW:0]    rem_diff;
   logic           quo_bit;
   logic           rsp_load;

   assign req_stall = (state_ff != cpfm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite &&
                      (paddr[cpfm_pkg::CSR_ADDR_W-1] == cpfm_pkg::CSR_IDX_TICK_RATE);

   always_comb begin
      if (paddr[cpfm_pkg::CSR_ADDR_W-1] == cpfm_pkg::CSR_IDX_TICK_RATE) begin
         prdata = cpfm_pkg::CSR_DATA_W'(tick_rate_ff);
      end else begin
         prdata = '0;
      end
   end

   assign stamp  = TW'(req_capture_time);
   assign period = stamp - first_ff;

   assign rem_shift = {rem_ff, quo_ff[QW-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign quo_bit   = !rem_diff[TW];

   assign rsp_load = (state_ff == cpfm_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      tick_rate_in = tick_rate_ff;
      pending_in   = pending_ff;
      first_in     = first_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      zero_in      = zero_ff;

      if (csr_write) begin
         tick_rate_in = pwdata[QW-1:0];
      end

      unique case (state_ff)
         cpfm_pkg::ST_IDLE: begin
            if (req_take) begin
               if (!pending_ff) begin
                  first_in   = stamp;
                  pending_in = 1'b1;
               end else begin
                  pending_in = 1'b0;
                  divisor_in = period;
                  rem_in     = '0;
                  quo_in     = tick_rate_ff;
                  count_in   = '0;
                  zero_in    = (period == '0);
                  state_in   = (period == '0) ? cpfm_pkg::ST_FINISH : cpfm_pkg::ST_DIVIDE;
               end
            end
         end
         cpfm_pkg::ST_DIVIDE: begin
            rem_in = quo_bit ? rem_diff[TW-1:0] : rem_shift[TW-1:0];
            quo_in = {quo_ff[QW-2:0], quo_bit};
            if (count_ff == CW'(cpfm_pkg::DIV_STEPS - 1)) begin
               count_in = '0;
               state_in = cpfm_pkg::ST_FINISH;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         cpfm_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = cpfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_period_in = rsp_period_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_zero_in   = rsp_zero_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_period_in = cpfm_pkg::PERIOD_W'(divisor_ff);
         rsp_freq_in   = zero_ff ? '0 : quo_ff;
         rsp_zero_in   = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpfm_pkg::ST_IDLE;
         tick_rate_ff <= cpfm_pkg::TICK_RATE_RESET;
         pending_ff   <= 1'b0;
         first_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_rate_ff <= tick_rate_in;
         pending_ff   <= pending_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      zero_ff       <= zero_in;
      rsp_period_ff <= rsp_period_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_period_count = rsp_period_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_zero_period  = rsp_zero_ff;

   a_zero_forces_freq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_ff |-> rsp_freq_ff == '0)
      else $error("zero period result carries nonzero frequency");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != cpfm_pkg::ST_DIVIDE |-> count_ff == '0)
      else $error("step counter running outside division");

   a_full_division: assert property (@(posedge clock) disable iff (reset)
      state_ff == cpfm_pkg::ST_DIVIDE && state_in == cpfm_pkg::ST_FINISH
      |-> count_ff == CW'(cpfm_pkg::DIV_STEPS - 1))
      else $error("division left before all quotient bits");

   a_pair_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff == cpfm_pkg::ST_FINISH |-> !pending_ff)
      else $error("pair phase not reset on second capture");

endmodule
